@@ design/mwsu_pkg.sv @@
// Shared types and constants for the material weight splat update block.
// Used by mwsu_divider and material_weight_splat_update_core; no dependencies.
`default_nettype none

package mwsu_pkg;

   localparam int SLOT_COUNT = 4;
   localparam int DIV_STAGES = 8;
   localparam logic [7:0] WEIGHT_FULL = 8'd255;

   typedef logic [SLOT_COUNT-1:0][7:0]  slots_type;
   typedef logic [SLOT_COUNT-1:0][15:0] products_type;

   // Per-item control and payload carried alongside the divider
   typedef struct packed {
      logic       changed;
      logic [1:0] target;
      logic [7:0] capped;
      logic       others_zero;
      slots_type  idx;
      slots_type  w;
   } side_type;

endpackage

`default_nettype wire

@@ design/mwsu_divider.sv @@
// Pipelined restoring divider, four lanes sharing one divisor, one quotient bit per stage.
// Depends on mwsu_pkg.
`default_nettype none

module mwsu_divider (
   input  wire logic                  clock,
   input  wire logic                  enable,
   input  wire mwsu_pkg::products_type num_in,
   input  wire logic [9:0]            den_in,
   output      mwsu_pkg::slots_type   quo_out
);

   localparam int NS = mwsu_pkg::DIV_STAGES;
   localparam int NL = mwsu_pkg::SLOT_COUNT;

   logic [9:0] rem_ff [NS][NL];
   logic [9:0] rem_in [NS][NL];
   logic [7:0] low_ff [NS][NL];
   logic [7:0] low_in [NS][NL];
   logic [7:0] quo_ff [NS][NL];
   logic [7:0] quo_in [NS][NL];
   logic [9:0] den_ff [NS];
   logic [9:0] den_in_s [NS];

   always_comb begin
      logic [9:0]  rem_src;
      logic [7:0]  low_src;
      logic [7:0]  quo_src;
      logic [9:0]  den_src;
      logic [10:0] trial;
      logic        ge;
      for (int s = 0; s < NS; s++) begin
         den_src = (s == 0) ? den_in : den_ff[(s == 0) ? 0 : s-1];
         den_in_s[s] = den_src;
         for (int l = 0; l < NL; l++) begin
            if (s == 0) begin
               rem_src = {2'b00, num_in[l][15:8]};
               low_src = num_in[l][7:0];
               quo_src = 8'd0;
            end else begin
               rem_src = rem_ff[(s == 0) ? 0 : s-1][l];
               low_src = low_ff[(s == 0) ? 0 : s-1][l];
               quo_src = quo_ff[(s == 0) ? 0 : s-1][l];
            end
            trial = {rem_src, low_src[7]};
            ge = (trial >= {1'b0, den_src});
            rem_in[s][l] = ge ? 10'(trial - {1'b0, den_src}) : trial[9:0];
            low_in[s][l] = {low_src[6:0], 1'b0};
            quo_in[s][l] = {quo_src[6:0], ge};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         for (int s = 0; s < NS; s++) begin
            den_ff[s] <= den_in_s[s];
            for (int l = 0; l < NL; l++) begin
               rem_ff[s][l] <= rem_in[s][l];
               low_ff[s][l] <= low_in[s][l];
               quo_ff[s][l] <= quo_in[s][l];
            end
         end
      end
   end

   always_comb begin
      for (int l = 0; l < NL; l++) begin
         quo_out[l] = quo_ff[NS-1][l];
      end
   end

endmodule

`default_nettype wire

@@ design/material_weight_splat_update_core.sv @@
// Top level of the material weight splat update block.
// Depends on mwsu_pkg and mwsu_divider.
`default_nettype none

// One texel update per cycle, sustained while the result side does not stall;
// each texel's result passes the stage 1, stage 2, divider and output registers.
// The stroke store is a MAP_DIM*MAP_DIM by 8 bit memory with one read and one
// write port; a repeated texel in consecutive cycles is forwarded from the
// pending write. The rescale divisions run in an 8-stage pipelined divider, one
// quotient bit per stage. After reset the block clears the stroke store, one
// entry per cycle, while req_ready stays low; csr writes are taken at any time.
module material_weight_splat_update_core #(
   parameter int MAP_DIM = 256
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       csr_write_enable,
   input  wire logic [7:0] csr_material_id,
   input  wire logic       req_valid,
   output      logic       req_ready,
   input  wire logic [7:0] req_texel_col,
   input  wire logic [7:0] req_texel_row,
   input  wire logic [7:0] req_brush_level,
   input  wire logic [7:0] req_slot_index_0,
   input  wire logic [7:0] req_slot_index_1,
   input  wire logic [7:0] req_slot_index_2,
   input  wire logic [7:0] req_slot_index_3,
   input  wire logic [7:0] req_slot_weight_0,
   input  wire logic [7:0] req_slot_weight_1,
   input  wire logic [7:0] req_slot_weight_2,
   input  wire logic [7:0] req_slot_weight_3,
   output      logic       rsp_valid,
   input  wire logic       rsp_ready,
   output      logic [7:0] rsp_new_index_0,
   output      logic [7:0] rsp_new_index_1,
   output      logic [7:0] rsp_new_index_2,
   output      logic [7:0] rsp_new_index_3,
   output      logic [7:0] rsp_new_weight_0,
   output      logic [7:0] rsp_new_weight_1,
   output      logic [7:0] rsp_new_weight_2,
   output      logic [7:0] rsp_new_weight_3,
   output      logic       rsp_texel_changed
);

   localparam int DEPTH = MAP_DIM * MAP_DIM;
   localparam int AW    = $clog2(DEPTH);
   localparam int NS    = mwsu_pkg::DIV_STAGES;
   localparam int NL    = mwsu_pkg::SLOT_COUNT;

   // Fold a coordinate into 0..MAP_DIM-1 by compare and subtract
   function automatic logic [11:0] fold_coord(input logic [7:0] v);
      logic [16:0] x;
      x = {9'd0, v};
      for (int k = 4; k >= 0; k--) begin
         if (x >= 17'(MAP_DIM << k)) begin
            x = x - 17'(MAP_DIM << k);
         end
      end
      return x[11:0];
   endfunction

   // Configuration and clearing pass
   logic [7:0]    material_ff;
   logic          clearing_ff;
   logic [AW-1:0] clr_addr_ff;

   // Stage 1
   logic                v1_ff;
   logic [AW-1:0]       a1_ff;
   logic [7:0]          level1_ff;
   mwsu_pkg::slots_type idx1_ff;
   mwsu_pkg::slots_type w1_ff;
   logic [7:0]          rd_ff;
   logic                fwd_v_ff;
   logic [AW-1:0]       fwd_addr_ff;
   logic [7:0]          fwd_data_ff;

   // Stage 2
   logic                v2_ff;
   mwsu_pkg::side_type  side2_ff;
   mwsu_pkg::side_type  side2_in;
   logic [7:0]          remain2_ff;
   logic [7:0]          remain2_in;
   logic [9:0]          others2_ff;
   logic [9:0]          others2_in;

   // Divider sideband
   logic                sv_ff [NS];
   mwsu_pkg::side_type  sd_ff [NS];

   // Output register
   logic                rsp_valid_ff;
   mwsu_pkg::slots_type out_idx_ff;
   mwsu_pkg::slots_type out_w_ff;
   logic                out_chg_ff;
   mwsu_pkg::slots_type out_idx_in;
   mwsu_pkg::slots_type out_w_in;

   logic [7:0]          mem [DEPTH];

   logic                enable;
   logic                accept;
   logic [AW-1:0]       req_addr;
   logic                mem_we;
   logic [AW-1:0]       mem_wa;
   logic [7:0]          mem_wd;
   logic                we_item;
   logic [7:0]          stored_new;
   mwsu_pkg::products_type prod;
   mwsu_pkg::slots_type quo;

   assign enable    = !rsp_valid_ff || rsp_ready;
   assign req_ready = enable && !clearing_ff;
   assign accept    = req_valid && req_ready;
   assign req_addr  = AW'(AW'(fold_coord(req_texel_row)) * AW'(MAP_DIM))
                      + AW'(fold_coord(req_texel_col));

   always_ff @(posedge clock) begin
      if (reset) begin
         material_ff <= 8'd0;
      end else if (csr_write_enable) begin
         material_ff <= csr_material_id;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff <= 1'b1;
         clr_addr_ff <= '0;
      end else if (clearing_ff) begin
         clr_addr_ff <= clr_addr_ff + 1'b1;
         if (clr_addr_ff == AW'(DEPTH - 1)) begin
            clearing_ff <= 1'b0;
         end
      end
   end

   // Stroke store
   assign mem_we = clearing_ff || we_item;
   assign mem_wa = clearing_ff ? clr_addr_ff : a1_ff;
   assign mem_wd = clearing_ff ? 8'd0 : stored_new;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      if (enable) begin
         rd_ff <= mem[req_addr];
      end
   end

   // Stage 1 registers
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff    <= 1'b0;
         fwd_v_ff <= 1'b0;
      end else if (enable) begin
         v1_ff    <= accept;
         fwd_v_ff <= we_item;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         a1_ff       <= req_addr;
         level1_ff   <= req_brush_level;
         idx1_ff     <= {req_slot_index_3, req_slot_index_2, req_slot_index_1,
                         req_slot_index_0};
         w1_ff       <= {req_slot_weight_3, req_slot_weight_2, req_slot_weight_1,
                         req_slot_weight_0};
         fwd_addr_ff <= a1_ff;
         fwd_data_ff <= stored_new;
      end
   end

   // Stage 1 logic: target slot, stroke level, capped weight, sum of the others
   always_comb begin
      logic       pass;
      logic       found;
      logic [1:0] tgt;
      logic [7:0] old_w;
      logic [7:0] stored_rd;
      logic [7:0] stored;
      logic [8:0] grown;
      logic [7:0] capped;
      logic [9:0] others;
      pass  = (level1_ff == 8'd0) || (level1_ff <= w1_ff[NL-1]);
      found = 1'b0;
      tgt   = 2'(NL - 1);
      for (int i = NL - 1; i >= 0; i--) begin
         if (idx1_ff[i] == material_ff || w1_ff[i] == 8'd0) begin
            found = 1'b1;
            tgt   = 2'(i);
         end
      end
      old_w     = found ? w1_ff[tgt] : 8'd0;
      stored_rd = (fwd_v_ff && fwd_addr_ff == a1_ff) ? fwd_data_ff : rd_ff;
      if (stored_rd == 8'd0) begin
         stored = (old_w != 8'd0) ? old_w : 8'd1;
      end else begin
         stored = stored_rd;
      end
      grown = {1'b0, stored} + {1'b0, level1_ff};
      if (grown < {1'b0, old_w}) begin
         grown = {1'b0, old_w};
      end
      capped = grown[8] ? mwsu_pkg::WEIGHT_FULL : grown[7:0];
      others = 10'd0;
      for (int i = 0; i < NL; i++) begin
         if (tgt != 2'(i)) begin
            others = others + {2'b00, w1_ff[i]};
         end
      end
      stored_new  = stored;
      we_item     = enable && v1_ff && !pass && (stored_rd == 8'd0);
      remain2_in  = mwsu_pkg::WEIGHT_FULL - capped;
      others2_in  = others;
      side2_in.changed     = !pass;
      side2_in.target      = tgt;
      side2_in.capped      = capped;
      side2_in.others_zero = (others == 10'd0);
      side2_in.w           = w1_ff;
      side2_in.idx         = idx1_ff;
      if (!pass) begin
         side2_in.idx[tgt] = material_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (enable) begin
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         side2_ff   <= side2_in;
         remain2_ff <= remain2_in;
         others2_ff <= others2_in;
      end
   end

   // Stage 2: scale products feed the divider
   always_comb begin
      for (int i = 0; i < NL; i++) begin
         prod[i] = side2_ff.w[i] * remain2_ff;
      end
   end

   mwsu_divider u_divider (
      .clock   (clock),
      .enable  (enable),
      .num_in  (prod),
      .den_in  (others2_ff),
      .quo_out (quo)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < NS; s++) begin
            sv_ff[s] <= 1'b0;
         end
      end else if (enable) begin
         sv_ff[0] <= v2_ff;
         for (int s = 1; s < NS; s++) begin
            sv_ff[s] <= sv_ff[s-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         sd_ff[0] <= side2_ff;
         for (int s = 1; s < NS; s++) begin
            sd_ff[s] <= sd_ff[s-1];
         end
      end
   end

   // Final stage: apply quotients, give the excess to slot 0, bubble the target up
   always_comb begin
      mwsu_pkg::side_type sd;
      logic [9:0] total;
      logic [1:0] t;
      logic [7:0] tmp;
      sd = sd_ff[NS-1];
      out_idx_in = sd.idx;
      out_w_in   = sd.w;
      total      = 10'd0;
      t          = sd.target;
      tmp        = 8'd0;
      if (sd.changed) begin
         for (int i = 0; i < NL; i++) begin
            if (sd.target == 2'(i)) begin
               out_w_in[i] = sd.capped;
            end else begin
               out_w_in[i] = sd.others_zero ? 8'd0 : quo[i];
            end
            total = total + {2'b00, out_w_in[i]};
         end
         out_w_in[0] = out_w_in[0] + 8'(10'd255 - total);
         for (int j = NL - 1; j >= 1; j--) begin
            if (t == 2'(j) && sd.capped > out_w_in[j-1]) begin
               tmp             = out_w_in[j];
               out_w_in[j]     = out_w_in[j-1];
               out_w_in[j-1]   = tmp;
               tmp             = out_idx_in[j];
               out_idx_in[j]   = out_idx_in[j-1];
               out_idx_in[j-1] = tmp;
               t               = 2'(j - 1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (enable) begin
         rsp_valid_ff <= sv_ff[NS-1];
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         out_idx_ff <= out_idx_in;
         out_w_ff   <= out_w_in;
         out_chg_ff <= sd_ff[NS-1].changed;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_new_index_0   = out_idx_ff[0];
   assign rsp_new_index_1   = out_idx_ff[1];
   assign rsp_new_index_2   = out_idx_ff[2];
   assign rsp_new_index_3   = out_idx_ff[3];
   assign rsp_new_weight_0  = out_w_ff[0];
   assign rsp_new_weight_1  = out_w_ff[1];
   assign rsp_new_weight_2  = out_w_ff[2];
   assign rsp_new_weight_3  = out_w_ff[3];
   assign rsp_texel_changed = out_chg_ff;

endmodule

`default_nettype wire

@@ design/mwsu_checker.sv @@
// Port-level checks for material_weight_splat_update_core, bound to the top level.
// Depends only on the top level's ports.
`default_nettype none

module mwsu_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_ready,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic [7:0] rsp_new_weight_0,
   input wire logic [7:0] rsp_new_weight_1,
   input wire logic [7:0] rsp_new_weight_2,
   input wire logic [7:0] rsp_new_weight_3,
   input wire logic       rsp_texel_changed
);

   // A painted texel always sums to full weight
   a_full_weight: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_texel_changed |->
         ({2'b00, rsp_new_weight_0} + {2'b00, rsp_new_weight_1}
          + {2'b00, rsp_new_weight_2} + {2'b00, rsp_new_weight_3}) == 10'd255)
      else $error("painted texel weights do not sum to 255");

   // Store clearing holds off input right after reset
   a_clear_after_reset: assert property (@(posedge clock)
      $past(reset) && !reset |-> !req_ready)
      else $error("input taken while stroke store is clearing");

   // No result can come out during the first cycle after reset
   a_no_early_result: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_new_weight_0)
         && $stable(rsp_texel_changed))
      else $error("stalled result changed");

endmodule

bind material_weight_splat_update_core mwsu_checker u_mwsu_checker (
   .clock             (clock),
   .reset             (reset),
   .req_ready         (req_ready),
   .rsp_valid         (rsp_valid),
   .rsp_ready         (rsp_ready),
   .rsp_new_weight_0  (rsp_new_weight_0),
   .rsp_new_weight_1  (rsp_new_weight_1),
   .rsp_new_weight_2  (rsp_new_weight_2),
   .rsp_new_weight_3  (rsp_new_weight_3),
   .rsp_texel_changed (rsp_texel_changed)
);

`default_nettype wire
